// ===== rtl/cor_pkg.sv =====
// ============================================================================
// cor_pkg - shared types and constants of the circle octant rasterizer
// Holds request and result formats, controller/datapath links and limits.
// ============================================================================
package cor_pkg;

    localparam int COORD_BITS  = 10;
    localparam int RADIUS_BITS = 6;
    localparam int OUT_BITS    = 12;
    localparam int STEP_BITS   = 7;
    localparam int DEC_BITS    = 11;
    localparam int COUNT_BITS  = 6;

    localparam logic [RADIUS_BITS-1:0] MAX_RADIUS   = RADIUS_BITS'(63);
    localparam logic [RADIUS_BITS-1:0] RESET_RADIUS = RADIUS_BITS'(50);
    localparam logic [COUNT_BITS-1:0]  MAX_RESULTS  = COUNT_BITS'(46);

    typedef struct packed {
        logic [COORD_BITS-1:0] center_col;
        logic [COORD_BITS-1:0] center_row;
    } t_req;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] col_plus_dx;
        logic signed [OUT_BITS-1:0] col_minus_dx;
        logic signed [OUT_BITS-1:0] col_plus_dy;
        logic signed [OUT_BITS-1:0] col_minus_dy;
        logic signed [OUT_BITS-1:0] row_plus_dy;
        logic signed [OUT_BITS-1:0] row_minus_dy;
        logic signed [OUT_BITS-1:0] row_plus_dx;
        logic signed [OUT_BITS-1:0] row_minus_dx;
        logic                       last_step;
    } t_res;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_sts;

endpackage

// ===== rtl/circle_octant_rasterizer_unit.sv =====
// ============================================================================
// circle_octant_rasterizer_unit - midpoint circle generator, eight-way symmetry
// Traces one octant per request and emits the reflected columns and rows.
// ============================================================================
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------
//  request   | start in, busy out        | i_req  (center_col/row)
//  result    | o_strobe, one cycle each  | o_res  (8 coords, last_step)
//  config    | i_cfg_we                  | i_cfg_wdata (circle_radius)
//
//  A request is a load step followed by one result per octant step,
//  at most 46 results per request (the MAX_RESULTS cap).
//  The decision loop advances one step per cycle; busy is high meanwhile.
//  Reset sets the radius to 50 and returns the sequencer to idle.
//  Results cannot be stalled; each is valid for a single cycle.
// ============================================================================
module circle_octant_rasterizer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cor_pkg::t_req                   i_req,
    output logic                            o_strobe,
    output cor_pkg::t_res                   o_res,
    input  logic                            i_cfg_we,
    input  logic [cor_pkg::RADIUS_BITS-1:0] i_cfg_wdata
);

    cor_pkg::t_cmd w_cmd;
    cor_pkg::t_sts w_sts;

    cor_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    cor_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res       (o_res)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe outside a trace");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last_step) |-> !busy)
        else $error("busy after last step");

    a_more_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last_step) |-> busy)
        else $error("trace ended without last step");
`endif

endmodule

// ===== rtl/cor_ctrl.sv =====
// ============================================================================
// cor_ctrl - sequencer of the circle trace
// Loads a request, steps the datapath once per cycle until the last octant step.
// ============================================================================
module cor_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  cor_pkg::t_sts i_sts,
    output cor_pkg::t_cmd o_cmd,
    output logic          busy,
    output logic          o_strobe
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;
    logic   n_strobe;

    always_comb begin
        n_state    = r_state;
        n_strobe   = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                n_strobe   = 1'b1;
                if (i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

// ===== rtl/cor_datapath.sv =====
// ============================================================================
// cor_datapath - decision loop, reflection adders and result register
// Holds radius, center, x, y, decision and step count; forms eight points.
// ============================================================================
module cor_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cor_pkg::RADIUS_BITS-1:0]   i_cfg_wdata,
    input  cor_pkg::t_req                     i_req,
    input  cor_pkg::t_cmd                     i_cmd,
    output cor_pkg::t_sts                     o_sts,
    output cor_pkg::t_res                     o_res
);

    localparam int SB = cor_pkg::STEP_BITS;
    localparam int DB = cor_pkg::DEC_BITS;
    localparam int OB = cor_pkg::OUT_BITS;
    localparam int CB = cor_pkg::COORD_BITS;
    localparam int RB = cor_pkg::RADIUS_BITS;

    logic [RB-1:0]                    r_radius;
    logic [CB-1:0]                    r_cx;
    logic [CB-1:0]                    r_cy;
    logic [SB-1:0]                    r_x;
    logic [SB-1:0]                    r_y;
    logic signed [DB-1:0]             r_d;
    logic [cor_pkg::COUNT_BITS-1:0]   r_count;
    cor_pkg::t_res                    r_res;

    logic [RB-1:0]        w_rsat;
    logic [SB-1:0]        n_x;
    logic [SB-1:0]        n_y;
    logic signed [DB-1:0] n_d;
    logic signed [DB-1:0] w_nx_s;
    logic signed [DB-1:0] w_ny_s;
    logic                 w_last;
    logic signed [OB-1:0] w_cx;
    logic signed [OB-1:0] w_cy;
    logic signed [OB-1:0] w_xo;
    logic signed [OB-1:0] w_yo;

    assign w_rsat = (i_cfg_wdata > cor_pkg::MAX_RADIUS) ? cor_pkg::MAX_RADIUS : i_cfg_wdata;

    always_comb begin
        n_x    = r_x + SB'(1);
        w_nx_s = $signed(DB'(n_x));
        if (r_d > $signed(DB'(0))) begin
            n_y    = r_y - SB'(1);
            w_ny_s = $signed(DB'(r_y)) - $signed(DB'(1));
            n_d    = r_d + ((w_nx_s - w_ny_s) <<< 2) + $signed(DB'(10));
        end else begin
            n_y    = r_y;
            w_ny_s = $signed(DB'(r_y));
            n_d    = r_d + (w_nx_s <<< 2) + $signed(DB'(6));
        end
        w_last = (w_ny_s < w_nx_s)
              || (r_count >= (cor_pkg::MAX_RESULTS - cor_pkg::COUNT_BITS'(1)));
    end

    assign w_cx = $signed(OB'(r_cx));
    assign w_cy = $signed(OB'(r_cy));
    assign w_xo = $signed(OB'(r_x));
    assign w_yo = $signed(OB'(r_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= cor_pkg::RESET_RADIUS;
        end else if (i_cfg_we) begin
            r_radius <= w_rsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= i_req.center_col;
            r_cy    <= i_req.center_row;
            r_x     <= '0;
            r_y     <= SB'(r_radius);
            r_d     <= $signed(DB'(3)) - $signed(DB'({r_radius, 1'b0}));
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_d     <= n_d;
            r_count <= r_count + cor_pkg::COUNT_BITS'(1);
            r_res.col_plus_dx  <= w_cx + w_xo;
            r_res.col_minus_dx <= w_cx - w_xo;
            r_res.col_plus_dy  <= w_cx + w_yo;
            r_res.col_minus_dy <= w_cx - w_yo;
            r_res.row_plus_dy  <= w_cy + w_yo;
            r_res.row_minus_dy <= w_cy - w_yo;
            r_res.row_plus_dx  <= w_cy + w_xo;
            r_res.row_minus_dx <= w_cy - w_xo;
            r_res.last_step    <= w_last;
        end
    end

    assign o_sts.last = w_last;
    assign o_res      = r_res;

endmodule

// ===== tb/tb.sv =====
// ============================================================================
// tb - self-checking bench for circle_octant_rasterizer_unit
// Drives circle centers under several radius settings and traces each circle
// in a local midpoint predictor. Every strobed result is checked field by
// field against the oldest predicted octant step. Sender pacing varies
// between phases.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            start       = 1'b0;
    logic                            busy;
    cor_pkg::t_req                   i_req       = '0;
    logic                            o_strobe;
    cor_pkg::t_res                   o_res;
    logic                            i_cfg_we    = 1'b0;
    logic [cor_pkg::RADIUS_BITS-1:0] i_cfg_wdata = '0;

    cor_pkg::t_res                   expected_points[$];
    logic [cor_pkg::RADIUS_BITS-1:0] radius_setting = cor_pkg::RESET_RADIUS;
    int                              idle_pct       = 0;
    int                              mismatches     = 0;
    int                              stall_cycles   = 0;

    circle_octant_rasterizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1ns i_clk = ~i_clk;

    function automatic void trace_circle(input cor_pkg::t_req req);
        int            cx, cy, r, x, y, d, nx, ny, nd, n;
        bit            last;
        cor_pkg::t_res p;
        cx = int'(req.center_col);
        cy = int'(req.center_row);
        r  = int'(radius_setting);
        if (r > int'(cor_pkg::MAX_RADIUS)) begin
            r = int'(cor_pkg::MAX_RADIUS);
        end
        x    = 0;
        y    = r;
        d    = 3 - 2 * r;
        n    = 0;
        last = 1'b0;
        while (!last) begin
            nx = x + 1;
            ny = y;
            if (d > 0) begin
                ny = y - 1;
                nd = d + 4 * (nx - ny) + 10;
            end else begin
                nd = d + 4 * nx + 6;
            end
            n++;
            last = (ny < nx) || (n >= int'(cor_pkg::MAX_RESULTS));
            p.col_plus_dx  = cor_pkg::OUT_BITS'(cx + x);
            p.col_minus_dx = cor_pkg::OUT_BITS'(cx - x);
            p.col_plus_dy  = cor_pkg::OUT_BITS'(cx + y);
            p.col_minus_dy = cor_pkg::OUT_BITS'(cx - y);
            p.row_plus_dy  = cor_pkg::OUT_BITS'(cy + y);
            p.row_minus_dy = cor_pkg::OUT_BITS'(cy - y);
            p.row_plus_dx  = cor_pkg::OUT_BITS'(cy + x);
            p.row_minus_dx = cor_pkg::OUT_BITS'(cy - x);
            p.last_step    = last;
            expected_points.push_back(p);
            x = nx;
            y = ny;
            d = nd;
        end
    endfunction

    task automatic check_coord(input string name,
                               input logic signed [cor_pkg::OUT_BITS-1:0] exp_v,
                               input logic signed [cor_pkg::OUT_BITS-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        cor_pkg::t_res exp_p;
        if (i_rst_n && o_strobe) begin
            if (expected_points.size() == 0) begin
                $error("o_res: expected no result, got %h", o_res);
                mismatches++;
            end else begin
                exp_p = expected_points.pop_front();
                check_coord("col_plus_dx",  exp_p.col_plus_dx,  o_res.col_plus_dx);
                check_coord("col_minus_dx", exp_p.col_minus_dx, o_res.col_minus_dx);
                check_coord("col_plus_dy",  exp_p.col_plus_dy,  o_res.col_plus_dy);
                check_coord("col_minus_dy", exp_p.col_minus_dy, o_res.col_minus_dy);
                check_coord("row_plus_dy",  exp_p.row_plus_dy,  o_res.row_plus_dy);
                check_coord("row_minus_dy", exp_p.row_minus_dy, o_res.row_minus_dy);
                check_coord("row_plus_dx",  exp_p.row_plus_dx,  o_res.row_plus_dx);
                check_coord("row_minus_dx", exp_p.row_minus_dx, o_res.row_minus_dx);
                if (o_res.last_step !== exp_p.last_step) begin
                    $error("last_step: expected %0d, got %0d",
                           exp_p.last_step, o_res.last_step);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("circle_octant_rasterizer_unit: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic issue_center(input logic [cor_pkg::COORD_BITS-1:0] col,
                                input logic [cor_pkg::COORD_BITS-1:0] row);
        int            gap;
        cor_pkg::t_req req;
        req.center_col = col;
        req.center_row = row;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (idle_pct > 0 && $urandom_range(99) < 8) begin
            gap += $urandom_range(48, 1);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        trace_circle(req);
    endtask

    task automatic drain_points();
        start <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [cor_pkg::RADIUS_BITS-1:0] r);
        drain_points();
        i_cfg_wdata <= r;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        radius_setting = r;
    endtask

    function automatic logic [cor_pkg::COORD_BITS-1:0] pick_coord();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return cor_pkg::COORD_BITS'($urandom_range(63));
            3:       return cor_pkg::COORD_BITS'(1023 - $urandom_range(63));
            default: return cor_pkg::COORD_BITS'($urandom);
        endcase
    endfunction

    task automatic test_reset_radius();
        issue_center(10'd512, 10'd512);
        issue_center(10'd0, 10'd0);
    endtask

    task automatic test_zero_radius();
        write_radius(6'd0);
        issue_center(10'd0, 10'd0);
        issue_center(10'd1023, 10'd1023);
        issue_center(10'd0, 10'd1023);
        issue_center(10'd1023, 10'd0);
    endtask

    task automatic test_full_radius();
        write_radius(6'd63);
        issue_center(10'd1023, 10'd0);
        issue_center(10'd0, 10'd0);
        issue_center(10'd1023, 10'd1023);
    endtask

    task automatic test_small_radii();
        write_radius(6'd1);
        issue_center(10'd0, 10'd1023);
        issue_center(10'd5, 10'd7);
        write_radius(6'd2);
        issue_center(10'd1, 10'd1022);
        write_radius(6'd3);
        issue_center(10'd100, 10'd200);
        write_radius(6'd42);
        issue_center(10'd341, 10'd682);
        write_radius(6'd21);
        issue_center(10'd682, 10'd341);
    endtask

    task automatic test_random_circles(input int pct);
        logic [cor_pkg::RADIUS_BITS-1:0] r;
        idle_pct = pct;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       r = cor_pkg::RADIUS_BITS'($urandom_range(3));
                1:       r = cor_pkg::RADIUS_BITS'($urandom_range(12, 4));
                2:       r = cor_pkg::RADIUS_BITS'($urandom_range(63));
                3:       r = (pct == 31) ? 6'd63 : (pct == 63) ? 6'd0
                                                 : cor_pkg::RADIUS_BITS'($urandom);
                default: r = cor_pkg::RADIUS_BITS'($urandom_range(7));
            endcase
            write_radius(r);
            for (int k = 0; k < 17; k++) begin
                if ($urandom_range(99) < 5) begin
                    drain_points();
                end
                issue_center(pick_coord(), pick_coord());
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 31;
        test_reset_radius();
        test_zero_radius();
        test_full_radius();
        test_small_radii();
        test_random_circles(31);
        test_random_circles(63);
        test_random_circles(0);
        drain_points();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("circle_octant_rasterizer_unit: match");
        end else begin
            $display("circle_octant_rasterizer_unit: mismatch");
        end
        $finish;
    end
endmodule
